/* hw/rtl/rrss_pkg.sv */
package rrss_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int TICK_BITS_DEF = 32;

   localparam logic [4:0] TASKS_RESET = 5'd1;

   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_SLEEP  = 2'd1;
   localparam logic [1:0] ACT_SELECT = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic [3:0] running_task;
      logic       ready_found;
      logic       sleep_rejected;
   } rsp_type;

   // strobes broadcast to every cell of the row
   typedef struct packed {
      logic tick;
      logic load;
      logic seed;
      logic advance;
   } cell_ctrl_type;

   // what the row reports back to the sequencer
   typedef struct packed {
      logic hit;
      logic sel_busy;
   } row_stat_type;

endpackage

/* hw/rtl/rrss_cell.sv */
module rrss_cell #(
   parameter int CELL_IDX  = 0,
   parameter int CNT_W     = 5,
   parameter int TICK_BITS = rrss_pkg::TICK_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rrss_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]       count,
   input  logic                   sel,
   input  logic [TICK_BITS-1:0]   load_val,
   input  logic                   token_in,
   output logic                   token_out,
   output logic                   pass_out,
   output logic                   wrap_out,
   output logic                   busy,
   output logic                   hit_next
);

   localparam logic [CNT_W-1:0] SLOT      = CNT_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] SLOT_NEXT = CNT_W'(CELL_IDX + 1);
   localparam logic             IS_IDLE   = (CELL_IDX == 0);

   logic [TICK_BITS-1:0] counter_ff, counter_in;
   logic                 token_ff, token_next_in;
   logic                 active, at_end;

   assign active = SLOT < count;
   assign at_end = SLOT_NEXT >= count;
   assign busy   = counter_ff != '0;

   // hand the token on, or back to the idle slot past the last slot in use
   assign token_out = token_ff;
   assign pass_out  = token_ff && !at_end;
   assign wrap_out  = token_ff && at_end;
   assign hit_next  = token_in && !IS_IDLE && !busy;

   always_comb begin
      counter_in = counter_ff;
      if (ctrl.tick && active && busy) begin
         counter_in = counter_ff - TICK_BITS'(1);
      end else if (ctrl.load && sel && !busy) begin
         counter_in = load_val;
      end
      token_next_in = token_ff;
      if (ctrl.seed) begin
         token_next_in = sel;
      end else if (ctrl.advance) begin
         token_next_in = token_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         token_ff   <= 1'b0;
      end else begin
         counter_ff <= counter_in;
         token_ff   <= token_next_in;
      end
   end

endmodule

/* hw/rtl/rrss_row.sv */
module rrss_row #(
   parameter int MAX_TASKS = rrss_pkg::MAX_TASKS_DEF,
   parameter int TICK_BITS = rrss_pkg::TICK_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rrss_pkg::cell_ctrl_type          ctrl,
   input  logic [$clog2(MAX_TASKS+1)-1:0]   count,
   input  logic [$clog2(MAX_TASKS)-1:0]     running,
   input  logic [TICK_BITS-1:0]             load_val,
   output rrss_pkg::row_stat_type           stat,
   output logic [MAX_TASKS-1:0]             tokens
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   logic [MAX_TASKS-1:0] sel, pass, wrap, busy, hit, token_in;

   always_comb begin
      sel = '0;
      sel[running] = 1'b1;
   end

   // slot zero takes the token from whichever cell wraps
   always_comb begin
      token_in    = pass << 1;
      token_in[0] = |wrap;
   end

   assign stat.hit      = |hit;
   assign stat.sel_busy = |(busy & sel);

   for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
      rrss_cell #(
         .CELL_IDX (k),
         .CNT_W    (CNT_W),
         .TICK_BITS(TICK_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .count    (count),
         .sel      (sel[k]),
         .load_val (load_val),
         .token_in (token_in[k]),
         .token_out(tokens[k]),
         .pass_out (pass[k]),
         .wrap_out (wrap[k]),
         .busy     (busy[k]),
         .hit_next (hit[k])
      );
   end

endmodule

/* hw/rtl/round_robin_sleep_scheduler.sv */
// Round-robin task scheduler with one sleep counter per task slot; slot zero is the idle
// task. Each request beat carries an action: tick decrements every nonzero counter of the
// slots in use, sleep loads the running task's counter (flagged and ignored if it is still
// counting), select walks round-robin from the running task to the next non-idle task
// whose counter is zero, or falls back to idle. Every beat yields one response beat.
// Tick, sleep and unused action codes need no walk: the response register is loaded at
// the accepting edge, and the next request is taken in the following cycle unless
// rsp_stall holds it. A select passes a token along the row of cells, one slot per cycle
// while the walk runs; it stops at the first ready task or after one round of the slots
// in use; with no task slots there is no walk. A finished result waits in the response
// register while the next request is accepted, if it is drained or empty. The user must
// write tasks_in_use through csr_write_enable only while the block is idle; not checked.
// Values above MAX_TASKS act as MAX_TASKS. All counters clear on reset; no clearing pass.
module round_robin_sleep_scheduler #(
   parameter int MAX_TASKS = rrss_pkg::MAX_TASKS_DEF,
   parameter int TICK_BITS = rrss_pkg::TICK_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrss_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrss_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [4:0]        csr_write_data
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W = $clog2(MAX_TASKS);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]       tasks_ff;
   logic [IDX_W-1:0] running_ff, running_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rrss_pkg::rsp_type rsp_ff, rsp_in;

   logic [CNT_W-1:0] count;
   logic [CNT_W-1:0] pos_ext;
   logic [IDX_W-1:0] pos_next;
   logic             out_free, req_accept;
   logic             walk_last, walk_done;

   rrss_pkg::cell_ctrl_type ctrl;
   rrss_pkg::row_stat_type  stat;
   logic [MAX_TASKS-1:0]    tokens;

   // saturate the slot count at the row length
   assign count = (32'(tasks_ff) > 32'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : CNT_W'(tasks_ff);

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;

   // slot the token moves to this cycle, mirrored here to report its index
   assign pos_ext  = CNT_W'(pos_ff) + CNT_W'(1);
   assign pos_next = (pos_ext >= count) ? '0 : IDX_W'(pos_ext);

   assign walk_last = (steps_ff + CNT_W'(1)) == count;
   assign walk_done = stat.hit || walk_last;

   always_comb begin
      ctrl.tick    = req_accept && (req_payload.action == rrss_pkg::ACT_TICK);
      ctrl.load    = req_accept && (req_payload.action == rrss_pkg::ACT_SLEEP);
      ctrl.seed    = req_accept && (req_payload.action == rrss_pkg::ACT_SELECT);
      // hold the token while a finished walk waits for the response register
      ctrl.advance = (state_ff == ST_WALK) && !(walk_done && !out_free);
   end

   rrss_row #(
      .MAX_TASKS(MAX_TASKS),
      .TICK_BITS(TICK_BITS)
   ) u_row (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .count   (count),
      .running (running_ff),
      .load_val(TICK_BITS'(req_payload.delay_ticks)),
      .stat    (stat),
      .tokens  (tokens)
   );

   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in        = 1'b1;
               rsp_in.running_task = 4'(running_ff);
               rsp_in.ready_found  = 1'b0;
               rsp_in.sleep_rejected = 1'b0;
               case (req_payload.action)
                  rrss_pkg::ACT_SLEEP: begin
                     rsp_in.sleep_rejected = stat.sel_busy;
                  end
                  rrss_pkg::ACT_SELECT: begin
                     if (count == '0) begin
                        running_in          = '0;
                        rsp_in.running_task = 4'd0;
                     end else begin
                        // drop the beat into the walk; respond when it ends
                        rsp_valid_in = 1'b0;
                        pos_in       = running_ff;
                        steps_in     = '0;
                        state_in     = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               if (out_free) begin
                  running_in            = stat.hit ? pos_next : '0;
                  rsp_valid_in          = 1'b1;
                  rsp_in.running_task   = stat.hit ? 4'(pos_next) : 4'd0;
                  rsp_in.ready_found    = stat.hit;
                  rsp_in.sleep_rejected = 1'b0;
                  state_in              = ST_IDLE;
               end
            end else begin
               pos_in   = pos_next;
               steps_in = steps_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         tasks_ff     <= rrss_pkg::TASKS_RESET;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            tasks_ff <= csr_write_data;
         end
      end
      pos_ff   <= pos_in;
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // exactly one token sits on the row during a walk
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> $onehot(tokens))
      else $error("token lost or duplicated during walk");

   // token and the tracked slot index agree
   a_token_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> tokens[pos_ff])
      else $error("token position differs from tracked slot");

   // a walk never outlives the slot count
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> steps_ff < count)
      else $error("walk ran past the slot count");

   // a found task is never the idle slot
   a_found_nonidle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ready_found |-> running_ff != '0 && !rsp_ff.sleep_rejected)
      else $error("select reported the idle slot as found");

endmodule
